// File: rtl/core/srpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// srpr_pkg: shared types of the stream read page resolver
// Command and status codes, controller states and the result record.
// ----------------------------------------------------------------------------
package srpr_pkg;

    // Default sizes handed to the top level
    localparam int SAMPLE_SLOTS_DEF = 16;
    localparam int PAGE_SLOTS_DEF   = 256;
    localparam int OFFSET_WIDTH_DEF = 48;

    // Fixed port field widths
    localparam int BYTES_W    = 48;
    localparam int PAGE_NUM_W = 32;
    localparam int IN_DATA_W  = 224;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 128;
    localparam int OUT_USER_W = 4;

    typedef enum logic [1:0] {
        CMD_WR_SAMPLE = 2'd0,
        CMD_WR_PAGE   = 2'd1,
        CMD_RESOLVE   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_WRITTEN      = 3'd0,
        ST_SMP_MISSING  = 3'd1,
        ST_OUT_OF_RANGE = 3'd2,
        ST_PREFETCH     = 3'd3,
        ST_PAGE_HIT     = 3'd4,
        ST_PAGE_MISSING = 3'd5
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_CHECK,
        S_REDUCE,
        S_WALK,
        S_PAGE_HIT,
        S_RESP
    } t_state;

    typedef struct packed {
        t_status                 status;
        logic                    resolved;
        logic [PAGE_NUM_W-1:0]   found_page;
        logic [BYTES_W-1:0]      absolute_offset;
        logic [BYTES_W-1:0]      readable_bytes;
    } t_result;

    // Result that carries only a status code
    function automatic t_result status_only(input t_status st);
        t_result r;
        r                 = '0;
        r.status          = st;
        return r;
    endfunction

endpackage

// File: rtl/core/stream_read_page_resolver_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stream_read_page_resolver_unit: sample and page table read resolver
// Write requests fill a sample table and a page table; a resolve request
// maps a payload-relative read offset onto the prefetch head or a page.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream (i_s_*) carries requests, tuser holds the command, tdata the
//   operands. Master stream (o_m_*) returns one response per request, tuser
//   holds status and resolved flag, tdata the location.
//   One request is handled at a time; o_s_tready is high only while the
//   controller is idle, from the cycle after the previous response was loaded.
//   A write goes straight from accept to the response state. A resolve scans
//   the sample slots until the key hits, then answers from the prefetch head
//   or on an out-of-range offset; else it runs the first_page / PAGE_SLOTS
//   reduction steps (none with 256 or more page slots) and walks the pages,
//   up to min(page_count, PAGE_SLOTS) of them, the full count on a missing
//   page. A sample with no pages answers page missing after the reduction; a
//   missing key answers after all SAMPLE_SLOTS slots are read. Both tables are
//   memories with separate read and write addresses, read one entry per
//   cycle; scan and walk are pipelined at one entry per cycle.
//   A stalled master holds the response in the output register; the next
//   request is still taken and, once finished, holds the controller.
//   Reset clears the in-use bits of the sample table, the controller and the
//   output valid. Table contents are not cleared and read as unknown until
//   written.
// ----------------------------------------------------------------------------
module stream_read_page_resolver_unit #(
    parameter int SAMPLE_SLOTS = srpr_pkg::SAMPLE_SLOTS_DEF,
    parameter int PAGE_SLOTS   = srpr_pkg::PAGE_SLOTS_DEF,
    parameter int OFFSET_WIDTH = srpr_pkg::OFFSET_WIDTH_DEF
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // request stream
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // [3:0] sample_slot, [11:4] page_slot, [27:12] sample_key,
    // [28] entry_valid, [76:29] offset_bytes, [124:77] size_bytes,
    // [172:125] prefetch_bytes, [180:173] first_page, [189:181] page_count,
    // [221:190] page_number, [223:222] zero
    input  logic [srpr_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // [1:0] command
    input  logic [srpr_pkg::IN_USER_W-1:0]    i_s_tuser,
    // response stream
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // [31:0] found_page, [79:32] absolute_offset, [127:80] readable_bytes
    output logic [srpr_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // [2:0] status, [3] resolved
    output logic [srpr_pkg::OUT_USER_W-1:0]   o_m_tuser
);

    localparam int OW  = OFFSET_WIDTH;
    localparam int SW  = (SAMPLE_SLOTS > 1) ? $clog2(SAMPLE_SLOTS) : 1;
    localparam int IW  = $clog2(SAMPLE_SLOTS + 1);
    localparam int PW  = (PAGE_SLOTS > 1) ? $clog2(PAGE_SLOTS) : 1;
    localparam int PTW = (PW > 8) ? PW : 8;
    localparam int CW  = ($clog2(PAGE_SLOTS + 1) > 9) ? $clog2(PAGE_SLOTS + 1) : 9;

    // Request fields
    logic [3:0]                      s_in_slot;
    logic [7:0]                      s_in_pslot;
    logic [15:0]                     s_in_key;
    logic                            s_in_valid;
    logic [OW-1:0]                   s_in_ofs;
    logic [OW-1:0]                   s_in_size;
    logic [OW-1:0]                   s_in_pre;
    logic [7:0]                      s_in_first;
    logic [8:0]                      s_in_count;
    logic [srpr_pkg::PAGE_NUM_W-1:0] s_in_pnum;
    srpr_pkg::t_cmd                  s_in_cmd;

    assign s_in_slot  = i_s_tdata[3:0];
    assign s_in_pslot = i_s_tdata[11:4];
    assign s_in_key   = i_s_tdata[27:12];
    assign s_in_valid = i_s_tdata[28];
    assign s_in_ofs   = OW'(i_s_tdata[76:29]);
    assign s_in_size  = OW'(i_s_tdata[124:77]);
    assign s_in_pre   = OW'(i_s_tdata[172:125]);
    assign s_in_first = i_s_tdata[180:173];
    assign s_in_count = i_s_tdata[189:181];
    assign s_in_pnum  = i_s_tdata[221:190];
    assign s_in_cmd   = srpr_pkg::t_cmd'(i_s_tuser);

    // Tables
    logic [SAMPLE_SLOTS-1:0]         r_in_use;
    logic [15:0]                     mem_key   [SAMPLE_SLOTS];
    logic [OW-1:0]                   mem_sofs  [SAMPLE_SLOTS];
    logic [OW-1:0]                   mem_ssize [SAMPLE_SLOTS];
    logic [OW-1:0]                   mem_spre  [SAMPLE_SLOTS];
    logic [7:0]                      mem_first [SAMPLE_SLOTS];
    logic [8:0]                      mem_count [SAMPLE_SLOTS];
    logic [srpr_pkg::PAGE_NUM_W-1:0] mem_pnum  [PAGE_SLOTS];
    logic [OW-1:0]                   mem_pofs  [PAGE_SLOTS];
    logic [OW-1:0]                   mem_pspan [PAGE_SLOTS];

    // Controller registers
    srpr_pkg::t_state  r_state, n_state;
    logic              r_ovld, n_ovld;
    logic              r_sv, n_sv;
    logic              r_pv1, n_pv1;
    logic              r_pv2, n_pv2;
    logic [IW-1:0]     r_idx, n_idx;
    logic [CW-1:0]     r_left, n_left;

    // Datapath registers
    logic [15:0]                     r_key, n_key;
    logic [OW-1:0]                   r_rel, n_rel;
    logic [OW-1:0]                   r_base, n_base;
    logic [OW-1:0]                   r_size, n_size;
    logic [OW-1:0]                   r_pre, n_pre;
    logic [OW-1:0]                   r_abs, n_abs;
    logic [PTW-1:0]                  r_ptr, n_ptr;
    logic [OW-1:0]                   r_p2_start, n_p2_start;
    logic [OW-1:0]                   r_p2_span, n_p2_span;
    logic [srpr_pkg::PAGE_NUM_W-1:0] r_p2_num, n_p2_num;
    logic [OW-1:0]                   r_end, n_end;
    logic [srpr_pkg::PAGE_NUM_W-1:0] r_num, n_num;
    srpr_pkg::t_result               r_res, n_res;
    srpr_pkg::t_result               r_out, n_out;

    // Memory read data
    logic                            r_sq_vbit;
    logic [15:0]                     r_sq_key;
    logic [OW-1:0]                   r_sq_ofs;
    logic [OW-1:0]                   r_sq_size;
    logic [OW-1:0]                   r_sq_pre;
    logic [7:0]                      r_sq_first;
    logic [8:0]                      r_sq_count;
    logic [srpr_pkg::PAGE_NUM_W-1:0] r_pq_num;
    logic [OW-1:0]                   r_pq_ofs;
    logic [OW-1:0]                   r_pq_span;

    logic              s_accept;
    logic              s_wr_smp;
    logic              s_wr_pg;
    logic [SW-1:0]     s_wr_sidx;
    logic [PW-1:0]     s_wr_pidx;
    logic [SW-1:0]     s_rd_sidx;
    logic [PW-1:0]     s_pg_addr;
    logic [OW-1:0]     s_end;
    logic              s_page_hit;
    logic [OW-1:0]     s_head_left;
    logic [OW-1:0]     s_page_left;

    assign o_s_tready = (r_state == srpr_pkg::S_IDLE);
    assign s_accept   = i_s_tvalid && o_s_tready;
    assign s_wr_smp   = s_accept && (s_in_cmd == srpr_pkg::CMD_WR_SAMPLE)
                        && (int'(s_in_slot) < SAMPLE_SLOTS);
    assign s_wr_pg    = s_accept && (s_in_cmd == srpr_pkg::CMD_WR_PAGE)
                        && (int'(s_in_pslot) < PAGE_SLOTS);
    assign s_wr_sidx  = SW'(s_in_slot);
    assign s_wr_pidx  = PW'(s_in_pslot);
    assign s_rd_sidx  = (int'(r_idx) < SAMPLE_SLOTS) ? r_idx[SW-1:0] : '0;
    assign s_pg_addr  = (r_state == srpr_pkg::S_WALK) ? r_ptr[PW-1:0] : '0;

    // Page containment test on the second walk stage
    assign s_end      = r_p2_start + r_p2_span;
    assign s_page_hit = r_pv2 && (r_rel >= r_p2_start) && (r_rel < s_end);

    // Bytes left in the head or the page, wrapping at the offset width
    assign s_head_left = r_pre - r_rel;
    assign s_page_left = r_end - r_rel;

    // In-use bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_use <= '0;
        end else if (s_wr_smp) begin
            r_in_use[s_wr_sidx] <= s_in_valid;
        end
    end

    // Table memories; writes happen only at accept, on their own write address,
    // while the read side reads every cycle
    always_ff @(posedge i_clk) begin
        if (s_wr_smp) begin
            mem_key[s_wr_sidx]   <= s_in_key;
            mem_sofs[s_wr_sidx]  <= s_in_ofs;
            mem_ssize[s_wr_sidx] <= s_in_size;
            mem_spre[s_wr_sidx]  <= s_in_pre;
            mem_first[s_wr_sidx] <= s_in_first;
            mem_count[s_wr_sidx] <= s_in_count;
        end
        r_sq_vbit  <= r_in_use[s_rd_sidx];
        r_sq_key   <= mem_key[s_rd_sidx];
        r_sq_ofs   <= mem_sofs[s_rd_sidx];
        r_sq_size  <= mem_ssize[s_rd_sidx];
        r_sq_pre   <= mem_spre[s_rd_sidx];
        r_sq_first <= mem_first[s_rd_sidx];
        r_sq_count <= mem_count[s_rd_sidx];
    end

    always_ff @(posedge i_clk) begin
        if (s_wr_pg) begin
            mem_pnum[s_wr_pidx]  <= s_in_pnum;
            mem_pofs[s_wr_pidx]  <= s_in_ofs;
            mem_pspan[s_wr_pidx] <= s_in_size;
        end
        r_pq_num  <= mem_pnum[s_pg_addr];
        r_pq_ofs  <= mem_pofs[s_pg_addr];
        r_pq_span <= mem_pspan[s_pg_addr];
    end

    // Controller state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= srpr_pkg::S_IDLE;
            r_ovld  <= 1'b0;
            r_sv    <= 1'b0;
            r_pv1   <= 1'b0;
            r_pv2   <= 1'b0;
            r_idx   <= '0;
            r_left  <= '0;
        end else begin
            r_state <= n_state;
            r_ovld  <= n_ovld;
            r_sv    <= n_sv;
            r_pv1   <= n_pv1;
            r_pv2   <= n_pv2;
            r_idx   <= n_idx;
            r_left  <= n_left;
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        r_key      <= n_key;
        r_rel      <= n_rel;
        r_base     <= n_base;
        r_size     <= n_size;
        r_pre      <= n_pre;
        r_abs      <= n_abs;
        r_ptr      <= n_ptr;
        r_p2_start <= n_p2_start;
        r_p2_span  <= n_p2_span;
        r_p2_num   <= n_p2_num;
        r_end      <= n_end;
        r_num      <= n_num;
        r_res      <= n_res;
        r_out      <= n_out;
    end

    // Next state and datapath
    always_comb begin
        n_state    = r_state;
        n_ovld     = r_ovld && !i_m_tready;
        n_sv       = r_sv;
        n_pv1      = r_pv1;
        n_pv2      = r_pv2;
        n_idx      = r_idx;
        n_left     = r_left;
        n_key      = r_key;
        n_rel      = r_rel;
        n_base     = r_base;
        n_size     = r_size;
        n_pre      = r_pre;
        n_abs      = r_abs;
        n_ptr      = r_ptr;
        n_p2_start = r_p2_start;
        n_p2_span  = r_p2_span;
        n_p2_num   = r_p2_num;
        n_end      = r_end;
        n_num      = r_num;
        n_res      = r_res;
        n_out      = r_out;

        case (r_state)
            srpr_pkg::S_IDLE: begin
                if (s_accept) begin
                    if (s_in_cmd == srpr_pkg::CMD_RESOLVE) begin
                        n_key   = s_in_key;
                        n_rel   = s_in_ofs;
                        n_idx   = '0;
                        n_sv    = 1'b0;
                        n_state = srpr_pkg::S_SEARCH;
                    end else begin
                        // writes and the unused code answer alike
                        n_res   = srpr_pkg::status_only(srpr_pkg::ST_WRITTEN);
                        n_state = srpr_pkg::S_RESP;
                    end
                end
            end

            // scan sample slots, one read issued and one checked per cycle
            srpr_pkg::S_SEARCH: begin
                n_sv = 1'b0;
                if (int'(r_idx) < SAMPLE_SLOTS) begin
                    n_sv  = 1'b1;
                    n_idx = r_idx + IW'(1);
                end
                if (r_sv && r_sq_vbit && (r_sq_key == r_key)) begin
                    n_base  = r_sq_ofs;
                    n_size  = r_sq_size;
                    n_pre   = r_sq_pre;
                    n_ptr   = PTW'(r_sq_first);
                    n_left  = (CW'(r_sq_count) > CW'(PAGE_SLOTS)) ? CW'(PAGE_SLOTS)
                                                                 : CW'(r_sq_count);
                    n_state = srpr_pkg::S_CHECK;
                end else if (!r_sv && (r_idx == IW'(SAMPLE_SLOTS))) begin
                    n_res   = srpr_pkg::status_only(srpr_pkg::ST_SMP_MISSING);
                    n_state = srpr_pkg::S_RESP;
                end
            end

            // range check and prefetch head
            srpr_pkg::S_CHECK: begin
                n_abs = r_base + r_rel;
                if (r_rel >= r_size) begin
                    n_res   = srpr_pkg::status_only(srpr_pkg::ST_OUT_OF_RANGE);
                    n_state = srpr_pkg::S_RESP;
                end else if (r_rel < r_pre) begin
                    n_res                 = srpr_pkg::status_only(srpr_pkg::ST_PREFETCH);
                    n_res.resolved        = 1'b1;
                    n_res.absolute_offset = srpr_pkg::BYTES_W'(n_abs);
                    n_res.readable_bytes  = srpr_pkg::BYTES_W'(s_head_left);
                    n_state               = srpr_pkg::S_RESP;
                end else begin
                    n_state = srpr_pkg::S_REDUCE;
                end
            end

            // bring the first page slot into table range
            srpr_pkg::S_REDUCE: begin
                n_pv1 = 1'b0;
                n_pv2 = 1'b0;
                if ({1'b0, r_ptr} >= (PTW + 1)'(PAGE_SLOTS)) begin
                    n_ptr = r_ptr - PTW'(PAGE_SLOTS);
                end else begin
                    n_state = srpr_pkg::S_WALK;
                end
            end

            // page walk: issue, offset stage, containment check
            srpr_pkg::S_WALK: begin
                n_pv1 = 1'b0;
                if (r_left != '0) begin
                    n_pv1  = 1'b1;
                    n_left = r_left - CW'(1);
                    n_ptr  = (r_ptr == PTW'(PAGE_SLOTS - 1)) ? '0 : r_ptr + PTW'(1);
                end
                n_pv2      = r_pv1;
                n_p2_start = r_pq_ofs - r_base;
                n_p2_span  = r_pq_span;
                n_p2_num   = r_pq_num;
                if (s_page_hit) begin
                    n_end   = s_end;
                    n_num   = r_p2_num;
                    n_state = srpr_pkg::S_PAGE_HIT;
                end else if (!r_pv2 && !r_pv1 && (r_left == '0)) begin
                    n_res   = srpr_pkg::status_only(srpr_pkg::ST_PAGE_MISSING);
                    n_state = srpr_pkg::S_RESP;
                end
            end

            srpr_pkg::S_PAGE_HIT: begin
                n_res                 = srpr_pkg::status_only(srpr_pkg::ST_PAGE_HIT);
                n_res.resolved        = 1'b1;
                n_res.found_page      = r_num;
                n_res.absolute_offset = srpr_pkg::BYTES_W'(r_abs);
                n_res.readable_bytes  = srpr_pkg::BYTES_W'(s_page_left);
                n_state               = srpr_pkg::S_RESP;
            end

            // hand the response to the output register once it is free
            srpr_pkg::S_RESP: begin
                if (!r_ovld || i_m_tready) begin
                    n_out   = r_res;
                    n_ovld  = 1'b1;
                    n_state = srpr_pkg::S_IDLE;
                end
            end

            default: begin
                n_state = srpr_pkg::S_IDLE;
            end
        endcase
    end

    // Response stream
    assign o_m_tvalid = r_ovld;
    assign o_m_tdata  = {r_out.readable_bytes, r_out.absolute_offset, r_out.found_page};
    assign o_m_tuser  = {r_out.resolved, r_out.status};

    // Assertions
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_accept |=> (r_state != srpr_pkg::S_IDLE))
        else $error("accepted request did not start processing");

    a_resolved_matches_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovld |-> (r_out.resolved == ((r_out.status == srpr_pkg::ST_PREFETCH) ||
                                       (r_out.status == srpr_pkg::ST_PAGE_HIT))))
        else $error("resolved flag disagrees with status");

    a_found_page_only_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ovld && (r_out.status != srpr_pkg::ST_PAGE_HIT)) |-> (r_out.found_page == '0))
        else $error("page number reported without a page hit");

    a_walk_ptr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpr_pkg::S_WALK) |-> (int'(r_ptr) < PAGE_SLOTS))
        else $error("page walk pointer outside the page table");

    a_walk_count_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == srpr_pkg::S_WALK) |-> (int'(r_left) <= PAGE_SLOTS))
        else $error("page walk longer than the page table");

endmodule
